>>> sv/chh_pkg.sv
// Package for the chained hash table: command and status codes, controller states.
// No dependencies.
package chh_pkg;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_SEARCH = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_NO_MEM    = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_HEAD,
    S_WALK,
    S_CHECK,
    S_ACT,
    S_ALLOC,
    S_LINK,
    S_REM2,
    S_FIN
  } state_t;

  localparam logic [2:0] ADDR_BUCKET_COUNT = 3'd0;

endpackage

>>> sv/chained_hash_table.sv
// Chained hash table of signed keys: bucket memory, node pool with free list, sequencer.
// Depends on chh_pkg and chh_mod.
//
//  channel | direction | handshake          | beat
//  in      | input     | in_valid/in_stall  | cmd, key
//  out     | output    | out_valid/out_stall| status, bucket, collided, entry_total
//  cfg     | input     | APB psel/penable   | bucket_count at address 0
//
// The modulo unit and the chain walk (one memory read per node) set how long an
// item takes.
// Reset and the clear command sweep every bucket of the bucket memory.
// in_stall is high while an item is in work or a sweep runs; a waiting result blocks the next one.
module chained_hash_table #(
  parameter int MAX_BUCKETS = 1024,
  parameter int POOL_NODES  = 256
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic [1:0]   cmd,
  input  logic signed [31:0] key,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [1:0]   status,
  output logic [9:0]   bucket,
  output logic         collided,
  output logic [8:0]   entry_total,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import chh_pkg::*;

  localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int MW = $clog2(MAX_BUCKETS + 1);
  localparam int NW = $clog2(POOL_NODES + 1);
  localparam int AW = $clog2(POOL_NODES);

  state_t state, state_next;

  logic [10:0]   bucket_count;
  logic [MW-1:0] modulus;

  logic [NW-1:0] heads_mem [MAX_BUCKETS];
  logic [31:0]   keys_mem  [POOL_NODES];
  logic [NW-1:0] links_mem [POOL_NODES];

  logic          h_we;
  logic [BW-1:0] h_waddr;
  logic [NW-1:0] h_wdata;
  logic [BW-1:0] h_raddr;
  logic [NW-1:0] h_rdata;
  logic          n_kwe;
  logic          n_lwe;
  logic [AW-1:0] n_kwaddr;
  logic [AW-1:0] n_lwaddr;
  logic [NW-1:0] n_lwdata;
  logic [AW-1:0] n_raddr;
  logic [31:0]   k_rdata;
  logic [NW-1:0] l_rdata;

  logic [BW-1:0] clr_ctr;
  logic          clr_reply;
  cmd_t          op;
  logic [31:0]   op_key;
  logic [BW-1:0] b;
  logic [NW-1:0] head;
  logic [NW-1:0] cur;
  logic [NW-1:0] prev;
  logic [NW:0]   steps;
  logic          found;
  logic [NW-1:0] node_link;
  logic [NW-1:0] fresh;
  logic [NW-1:0] free_head;
  logic [NW-1:0] never_used;
  logic [NW-1:0] stored;
  status_t       res_status;
  logic          res_coll;

  logic          mod_start;
  logic          mod_done;
  logic [BW-1:0] mod_rem;
  logic          cur_ok;
  logic          free_ok;
  logic          head_ok;
  logic          walk_end;

  function automatic logic node_ok(logic [NW-1:0] n);
    return (n != '0) && (32'(n) <= 32'(POOL_NODES));
  endfunction

  function automatic logic [AW-1:0] naddr(logic [NW-1:0] n);
    logic [NW-1:0] d;
    d = n - NW'(1);
    return d[AW-1:0];
  endfunction

  assign cur_ok   = node_ok(cur);
  assign free_ok  = node_ok(free_head);
  assign head_ok  = node_ok(head);
  assign walk_end = !cur_ok || (steps == (NW+1)'(POOL_NODES));

  assign modulus = (bucket_count == 11'd0) ? MW'(1) :
                   (32'(bucket_count) > 32'(MAX_BUCKETS)) ? MW'(MAX_BUCKETS) :
                   MW'(bucket_count);

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_BUCKET_COUNT) ? {21'd0, bucket_count} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_count <= 11'(MAX_BUCKETS);
    end else if (psel && penable && pwrite && pready && paddr == ADDR_BUCKET_COUNT) begin
      bucket_count <= pwdata[10:0];
    end
  end

  assign mod_start = (state == S_IDLE) && in_valid && (cmd_t'(cmd) != CMD_CLEAR);

  chh_mod #(.MW(MW), .BW(BW)) u_mod (
    .clk     (clk),
    .rst     (rst),
    .start   (mod_start),
    .key     (key),
    .modulus (modulus),
    .done    (mod_done),
    .rem_out (mod_rem)
  );

  assign in_stall = (state != S_IDLE);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (clr_ctr == BW'(MAX_BUCKETS - 1)) begin
        state_next = clr_reply ? S_FIN : S_IDLE;
      end
      S_IDLE: if (in_valid) begin
        state_next = (cmd_t'(cmd) == CMD_CLEAR) ? S_CLEAR : S_MOD;
      end
      S_MOD: if (mod_done) begin
        state_next = S_HEAD;
      end
      S_HEAD: state_next = S_WALK;
      S_WALK: state_next = walk_end ? S_ACT : S_CHECK;
      S_CHECK: state_next = (k_rdata == op_key) ? S_ACT : S_WALK;
      S_ACT: begin
        case (op)
          CMD_INSERT: begin
            if (found) state_next = S_FIN;
            else if (free_ok) state_next = S_ALLOC;
            else if (32'(never_used) < 32'(POOL_NODES)) state_next = S_LINK;
            else state_next = S_FIN;
          end
          CMD_REMOVE: state_next = found ? S_REM2 : S_FIN;
          default: state_next = S_FIN;
        endcase
      end
      S_ALLOC: state_next = S_LINK;
      S_LINK: state_next = S_FIN;
      S_REM2: state_next = S_FIN;
      S_FIN: if (!out_valid || !out_stall) begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    h_we     = 1'b0;
    h_waddr  = b;
    h_wdata  = '0;
    n_kwe    = 1'b0;
    n_lwe    = 1'b0;
    n_kwaddr = naddr(fresh);
    n_lwaddr = naddr(fresh);
    n_lwdata = head;
    n_raddr  = (state == S_ACT) ? naddr(free_head) : naddr(cur);
    case (state)
      S_CLEAR: begin
        h_we    = 1'b1;
        h_waddr = clr_ctr;
      end
      S_LINK: begin
        h_we    = 1'b1;
        h_wdata = fresh;
        n_kwe   = 1'b1;
        n_lwe   = 1'b1;
      end
      S_ACT: if (op == CMD_REMOVE && found) begin
        if (prev == '0) begin
          h_we    = 1'b1;
          h_wdata = node_link;
        end else begin
          n_lwe    = 1'b1;
          n_lwaddr = naddr(prev);
          n_lwdata = node_link;
        end
      end
      S_REM2: begin
        n_lwe    = 1'b1;
        n_lwaddr = naddr(cur);
        n_lwdata = free_head;
      end
      default: ;
    endcase
  end

  assign h_raddr = (state == S_MOD) ? mod_rem : b;

  always_ff @(posedge clk) begin
    if (h_we) heads_mem[h_waddr] <= h_wdata;
    h_rdata <= heads_mem[h_raddr];
  end

  always_ff @(posedge clk) begin
    if (n_kwe) keys_mem[n_kwaddr] <= op_key;
    if (n_lwe) links_mem[n_lwaddr] <= n_lwdata;
    k_rdata <= keys_mem[n_raddr];
    l_rdata <= links_mem[n_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_ctr    <= '0;
      clr_reply  <= 1'b0;
      free_head  <= '0;
      never_used <= '0;
      stored     <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && !out_stall && state != S_FIN) out_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          if (clr_ctr == BW'(MAX_BUCKETS - 1)) clr_ctr <= '0;
          else clr_ctr <= clr_ctr + BW'(1);
        end
        S_IDLE: if (in_valid) begin
          op         <= cmd_t'(cmd);
          op_key     <= key;
          res_status <= ST_OK;
          res_coll   <= 1'b0;
          found      <= 1'b0;
          b          <= '0;
          if (cmd_t'(cmd) == CMD_CLEAR) begin
            clr_reply  <= 1'b1;
            clr_ctr    <= '0;
            free_head  <= '0;
            never_used <= '0;
            stored     <= '0;
          end
        end
        S_MOD: if (mod_done) begin
          b <= mod_rem;
        end
        S_HEAD: begin
          head  <= h_rdata;
          cur   <= h_rdata;
          prev  <= '0;
          steps <= '0;
        end
        S_WALK: if (walk_end) begin
          found <= 1'b0;
        end
        S_CHECK: begin
          if (k_rdata == op_key) begin
            found     <= 1'b1;
            node_link <= l_rdata;
          end else begin
            prev  <= cur;
            cur   <= l_rdata;
            steps <= steps + (NW+1)'(1);
          end
        end
        S_ACT: begin
          case (op)
            CMD_INSERT: if (!found) begin
              if (free_ok) begin
                fresh <= free_head;
              end else if (32'(never_used) < 32'(POOL_NODES)) begin
                fresh      <= never_used + NW'(1);
                never_used <= never_used + NW'(1);
              end else begin
                res_status <= ST_NO_MEM;
              end
            end
            CMD_SEARCH: if (!found) res_status <= ST_NOT_FOUND;
            CMD_REMOVE: if (!found) res_status <= ST_NOT_FOUND;
            default: ;
          endcase
        end
        S_ALLOC: free_head <= l_rdata;
        S_LINK: begin
          res_coll <= head_ok;
          stored   <= stored + NW'(1);
        end
        S_REM2: begin
          free_head <= cur;
          if (stored != '0) stored <= stored - NW'(1);
        end
        S_FIN: if (!out_valid || !out_stall) begin
          out_valid   <= 1'b1;
          clr_reply   <= 1'b0;
          status      <= res_status;
          bucket      <= 10'(b);
          collided    <= res_coll;
          entry_total <= 9'(stored);
        end
        default: ;
      endcase
    end
  end

endmodule

>>> sv/chh_mod.sv
// Sequential modulo unit: non-negative remainder of a signed 32-bit key by a modulus.
// One quotient bit per cycle. Uses chh_pkg only for house consistency.
module chh_mod #(
  parameter int MW = 11,
  parameter int BW = 10
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [31:0]   key,
  input  logic [MW-1:0]        modulus,
  output logic                 done,
  output logic [BW-1:0]        rem_out
);
  import chh_pkg::*;

  logic          busy;
  logic [4:0]    cnt;
  logic [31:0]   quo;
  logic [MW-1:0] rem;
  logic          neg;
  logic [MW-1:0] m;
  logic [MW:0]   shifted;
  logic [MW:0]   diff;
  logic [MW-1:0] rem_next;
  logic [MW-1:0] fixed;

  assign shifted  = {rem, quo[31]};
  assign diff     = shifted - {1'b0, m};
  assign rem_next = (shifted >= {1'b0, m}) ? diff[MW-1:0] : shifted[MW-1:0];
  assign fixed    = (neg && rem != '0) ? m - rem : rem;
  assign rem_out  = fixed[BW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        m    <= modulus;
        neg  <= key[31];
        quo  <= key[31] ? 32'(-key) : 32'(key);
      end else if (busy) begin
        rem <= rem_next;
        quo <= {quo[30:0], 1'b0};
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> test/chained_hash_table_tb.sv
// Testbench for chained_hash_table: directed table then random insert/search/remove/clear
// traffic, checked beat by beat against an internal set model. Depends on chh_pkg and the RTL.
`timescale 1ns / 100ps

module chained_hash_table_tb;
  import chh_pkg::*;

  localparam int NBKT  = 1024;
  localparam int NPOOL = 256;
  localparam int WATCHDOG = 20000;

  typedef struct packed {
    status_t    status;
    logic [9:0] bucket;
    logic       collided;
    logic [8:0] entry_total;
  } result_t;

  typedef struct {
    cmd_t        op;
    logic [31:0] key;
    bit          typed;
    result_t     res;
  } row_t;

  logic clk = 0, rst = 1;
  logic in_valid = 0, out_stall = 0;
  logic [1:0] cmd = CMD_CLEAR;
  logic signed [31:0] key = 0;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [2:0] paddr = 0;
  logic [31:0] pwdata = 0;
  logic in_stall, out_valid, collided, pready;
  logic [1:0] status;
  logic [9:0] bucket;
  logic [8:0] entry_total;
  logic [31:0] prdata;

  chained_hash_table DUT (.*);

  always #1 clk = ~clk;

  // set model: chains in a pool with a free list
  int unsigned head_of [NBKT];
  logic [31:0] nkey [NPOOL + 1];
  int unsigned nlink [NPOOL + 1];
  int unsigned free_head, fresh_used, stored, modulus;

  result_t pending [$];
  int errors = 0;
  int idle_cycles = 0;
  bit no_idle = 0;

  function automatic void table_clear();
    foreach (head_of[i]) head_of[i] = 0;
    free_head = 0; fresh_used = 0; stored = 0;
  endfunction

  function automatic result_t table_apply(cmd_t op, logic [31:0] k);
    result_t r;
    longint m, kv, rem;
    int unsigned b, cur, prv, hit, steps, nn;
    r = '{ST_OK, 10'd0, 1'b0, 9'd0};
    if (op == CMD_CLEAR) begin
      table_clear();
    end else begin
      m = modulus < 1 ? 1 : (modulus > NBKT ? NBKT : modulus);
      kv = longint'($signed(k));
      rem = kv % m;
      if (rem < 0) rem += m;
      b = 32'(rem);
      cur = head_of[b]; prv = 0; hit = 0; steps = 0;
      while (cur >= 1 && cur <= NPOOL && steps < NPOOL && hit == 0) begin
        if (nkey[cur] == k) hit = cur;
        else begin
          prv = cur; cur = nlink[cur]; steps++;
        end
      end
      r.bucket = 10'(b);
      if (op == CMD_INSERT) begin
        if (hit == 0) begin
          nn = 0;
          if (free_head >= 1 && free_head <= NPOOL) begin
            nn = free_head; free_head = nlink[nn];
          end else if (fresh_used < NPOOL) begin
            fresh_used++; nn = fresh_used;
          end
          if (nn == 0) r.status = ST_NO_MEM;
          else begin
            r.collided = head_of[b] != 0;
            nkey[nn] = k; nlink[nn] = head_of[b]; head_of[b] = nn; stored++;
          end
        end
      end else if (hit == 0) begin
        r.status = ST_NOT_FOUND;
      end else if (op == CMD_REMOVE) begin
        if (prv == 0) head_of[b] = nlink[hit];
        else nlink[prv] = nlink[hit];
        nlink[hit] = free_head; free_head = hit;
        if (stored > 0) stored--;
      end
    end
    r.entry_total = 9'(stored);
    return r;
  endfunction

  // output side: random stall, check beats
  always @(posedge clk) begin
    result_t got, exp_r;
    if (!rst && out_valid && !out_stall) begin
      got = '{status_t'(status), bucket, collided, entry_total};
      if (pending.size() == 0) begin
        $error("unexpected result beat"); errors++;
      end else begin
        exp_r = pending.pop_front();
        if (got.status != exp_r.status) begin
          $error("status exp %0d got %0d", exp_r.status, got.status); errors++;
        end
        if (got.bucket != exp_r.bucket) begin
          $error("bucket exp %0d got %0d", exp_r.bucket, got.bucket); errors++;
        end
        if (got.collided != exp_r.collided) begin
          $error("collided exp %0d got %0d", exp_r.collided, got.collided); errors++;
        end
        if (got.entry_total != exp_r.entry_total) begin
          $error("entry_total exp %0d got %0d", exp_r.entry_total, got.entry_total);
          errors++;
        end
      end
    end
    out_stall <= no_idle ? 1'b0 : ($urandom_range(99) < 11);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("chained_hash_table test failed");
      $finish;
    end
  end

  task automatic send_beat(cmd_t op, logic [31:0] k);
    while (!no_idle && $urandom_range(99) < 11) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1; cmd <= op; key <= k;
    do @(posedge clk); while (in_stall);
    pending.push_back(table_apply(op, k));
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_modulus(int unsigned v);
    psel <= 1; pwrite <= 1; paddr <= ADDR_BUCKET_COUNT; pwdata <= v;
    @(posedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    psel <= 0; penable <= 0; pwrite <= 0;
    modulus = v & 11'h7FF;
    @(posedge clk);
  endtask

  task automatic random_phase(int n, int keyspan);
    int unsigned p;
    logic [31:0] k;
    for (int i = 0; i < n; i++) begin
      p = $urandom_range(99);
      k = keyspan == 0 ? $urandom() : $signed($urandom_range(2 * keyspan)) - keyspan;
      if (p < 45) send_beat(CMD_INSERT, k);
      else if (p < 70) send_beat(CMD_SEARCH, k);
      else if (p < 98) send_beat(CMD_REMOVE, k);
      else send_beat(CMD_CLEAR, k);
    end
  endtask

  row_t rows [$];

  initial begin
    row_t rw;
    table_clear();
    modulus = NBKT;
    rows = '{
      '{CMD_SEARCH, 32'd5, 1, '{ST_NOT_FOUND, 10'd5, 1'b0, 9'd0}},
      '{CMD_INSERT, 32'd5, 1, '{ST_OK, 10'd5, 1'b0, 9'd1}},
      '{CMD_INSERT, 32'd5, 1, '{ST_OK, 10'd5, 1'b0, 9'd1}},
      '{CMD_INSERT, 32'd1029, 1, '{ST_OK, 10'd5, 1'b1, 9'd2}},
      '{CMD_INSERT, 32'd2053, 0, '0},
      '{CMD_INSERT, 32'h7FFFFFFF, 1, '{ST_OK, 10'd1023, 1'b0, 9'd4}},
      '{CMD_INSERT, 32'h80000000, 1, '{ST_OK, 10'd0, 1'b0, 9'd5}},
      '{CMD_INSERT, 32'hFFFFFFFF, 1, '{ST_OK, 10'd1023, 1'b1, 9'd6}},
      '{CMD_SEARCH, 32'd1029, 0, '0},
      '{CMD_REMOVE, 32'd1029, 0, '0},
      '{CMD_REMOVE, 32'd2053, 0, '0},
      '{CMD_REMOVE, 32'd2053, 0, '0},
      '{CMD_SEARCH, 32'd5, 0, '0},
      '{CMD_INSERT, 32'd7, 0, '0},
      '{CMD_REMOVE, 32'd0, 0, '0},
      '{CMD_CLEAR, 32'hFFFFFFFF, 1, '{ST_OK, 10'd0, 1'b0, 9'd0}},
      '{CMD_SEARCH, 32'hFFFFFFFF, 1, '{ST_NOT_FOUND, 10'd1023, 1'b0, 9'd0}}
    };
    repeat (10) @(posedge clk);
    rst <= 0;
    foreach (rows[i]) begin
      rw = rows[i];
      send_beat(rw.op, rw.key);
      if (rw.typed && pending[$] != rw.res) begin
        $error("row %0d table entry exp %p model %p", i, rw.res, pending[$]); errors++;
      end
    end
    drain();

    // pool exhaustion, then free-list reuse
    no_idle = 1;
    for (int i = 0; i < NPOOL + 3; i++) send_beat(CMD_INSERT, $urandom());
    random_phase(60, 0);
    no_idle = 0;
    send_beat(CMD_CLEAR, 0);
    drain();

    write_modulus(1);
    random_phase(150, 40);
    drain();
    write_modulus(0);
    random_phase(80, 40);
    drain();
    write_modulus(2047);
    random_phase(100, 3000);
    drain();
    write_modulus(7);
    random_phase(300, 60);
    drain();
    write_modulus(NBKT);
    random_phase(150, 0);
    drain();
    write_modulus($urandom_range(2, NBKT));
    random_phase(250, 500);
    drain();

    if (errors == 0) $display("chained_hash_table test passed");
    else $display("chained_hash_table test failed");
    $finish;
  end
endmodule
